[src/hlva_pkg.sv]
// ----------------------------------------------------------------------------
// hlva_pkg
// Shared types, codes and constants of the Hough line vote accumulator.
// ----------------------------------------------------------------------------
package hlva_pkg;

    localparam int ANGLE_BINS_DEF  = 256;
    localparam int RADIUS_BINS_DEF = 256;
    localparam int MAX_DIM_DEF     = 1024;

    localparam int DIM_W      = 11;
    localparam int QUOT_W     = 16;
    localparam int CFG_ADDR_W = 3;

    localparam logic [63:0] PI_Q30        = 64'd3373259426;
    localparam logic [63:0] ONE_Q30       = 64'd1073741824;
    localparam int          INV_SQRT2_Q20 = 741455;

    localparam logic [DIM_W-1:0] IMAGE_WIDTH_RST  = 11'd512;
    localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RST = 11'd512;

    // register index = paddr[2]
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    localparam logic [1:0] OP_VOTE  = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    typedef struct packed {
        logic [1:0]  operation;
        logic [9:0]  pixel_x;
        logic [9:0]  pixel_y;
        logic [15:0] edge_weight;
        logic [7:0]  angle_bin;
        logic [7:0]  radius_bin;
    } vote_in_t;

    typedef struct packed {
        logic [31:0] cell_value;
        logic [8:0]  votes_cast;
    } result_t;

    // Q30 -> Q1.15, round half up, clamp to [0, 32767]
    function automatic logic [15:0] q30_to_q15(input logic signed [63:0] v);
        logic [63:0] q;
        if (v < 0) begin
            q = 64'd0;
        end else begin
            q = (64'(v) + 64'd16384) >> 15;
        end
        return (q > 64'd32767) ? 16'd32767 : q[15:0];
    endfunction

endpackage

[src/hough_line_vote_accumulator.sv]
// ----------------------------------------------------------------------------
// hough_line_vote_accumulator
// Hough line voting engine over an ANGLE_BINS x RADIUS_BINS store of 32-bit
// saturating counters held in one RAM; vote, read-cell and clear beats.
// ----------------------------------------------------------------------------
// Vote: a normalising division, then one angle bin per cycle
//   through a five-stage read-modify-write pipe and a drain.
// Read: one RAM read. Clear: a sweep that writes zero to every cell.
// Zero-weight, out-of-image and no-op beats skip the store. One beat at a time.
// Reset: synchronous; then a clearing pass over all ANGLE_BINS*RADIUS_BINS cells
//   (65536 by default) with s_ready low; the APB port stays live.
module hough_line_vote_accumulator #(
    parameter int ANGLE_BINS  = hlva_pkg::ANGLE_BINS_DEF,
    parameter int RADIUS_BINS = hlva_pkg::RADIUS_BINS_DEF,
    parameter int MAX_DIM     = hlva_pkg::MAX_DIM_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  hlva_pkg::vote_in_t                s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output hlva_pkg::result_t                 m_data,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [hlva_pkg::CFG_ADDR_W-1:0]   paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    localparam int NCELLS = ANGLE_BINS * RADIUS_BINS;
    localparam int AW     = $clog2(NCELLS);
    localparam int KW     = $clog2(ANGLE_BINS);
    localparam int CW     = $clog2(ANGLE_BINS + 1);
    localparam int DW     = hlva_pkg::DIM_W;
    localparam int QW     = hlva_pkg::QUOT_W;

    localparam logic [KW-1:0] K_LAST   = KW'(ANGLE_BINS - 1);
    localparam logic [AW-1:0] CLR_LAST = AW'(NCELLS - 1);
    localparam logic [10:0]   A_LIM    = 11'(ANGLE_BINS);
    localparam logic [10:0]   R_LIM    = 11'(RADIUS_BINS);
    localparam logic [29:0]   R_SCALE  = 30'(RADIUS_BINS * hlva_pkg::INV_SQRT2_Q20);
    localparam int            DIM_CLIP = (MAX_DIM > 2047) ? 2047 : MAX_DIM;
    localparam logic [DW-1:0] DIM_MAX  = DW'(DIM_CLIP);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_DIV    = 3'd2;
    localparam logic [2:0] ST_WALK   = 3'd3;
    localparam logic [2:0] ST_DRAIN  = 3'd4;
    localparam logic [2:0] ST_RDWAIT = 3'd5;
    localparam logic [2:0] ST_OUT    = 3'd6;

    // ---- cos/sin table, Q1.15: {signed cos, sin} ----
    localparam logic [63:0] NA = 64'(ANGLE_BINS);
    logic [31:0] trig_tab [ANGLE_BINS];

    for (genvar k = 0; k < ANGLE_BINS; k++) begin : g_trig
        localparam logic [63:0] KI   = 64'(k);
        localparam bit          NEG  = (2 * KI > NA);
        localparam logic [63:0] KF   = NEG ? (NA - KI) : KI;
        localparam bit          SWAP = (4 * KF > NA);
        localparam logic [63:0] ANG  = SWAP ? ((NA - 2 * KF) * hlva_pkg::PI_Q30) / (2 * NA)
                                            : (KF * hlva_pkg::PI_Q30) / NA;
        localparam logic [63:0] X2   = (ANG * ANG) >> 30;
        localparam logic [63:0] TS1  = ((ANG * X2) >> 30) / 6;
        localparam logic [63:0] TS2  = ((TS1 * X2) >> 30) / 20;
        localparam logic [63:0] TS3  = ((TS2 * X2) >> 30) / 42;
        localparam logic [63:0] TS4  = ((TS3 * X2) >> 30) / 72;
        localparam logic [63:0] TS5  = ((TS4 * X2) >> 30) / 110;
        localparam logic [63:0] TS6  = ((TS5 * X2) >> 30) / 156;
        localparam logic [63:0] TC1  = ((hlva_pkg::ONE_Q30 * X2) >> 30) / 2;
        localparam logic [63:0] TC2  = ((TC1 * X2) >> 30) / 12;
        localparam logic [63:0] TC3  = ((TC2 * X2) >> 30) / 30;
        localparam logic [63:0] TC4  = ((TC3 * X2) >> 30) / 56;
        localparam logic [63:0] TC5  = ((TC4 * X2) >> 30) / 90;
        localparam logic [63:0] TC6  = ((TC5 * X2) >> 30) / 132;
        localparam logic signed [63:0] SS = $signed(ANG) - $signed(TS1) + $signed(TS2)
                                          - $signed(TS3) + $signed(TS4) - $signed(TS5)
                                          + $signed(TS6);
        localparam logic signed [63:0] SC = $signed(hlva_pkg::ONE_Q30) - $signed(TC1)
                                          + $signed(TC2) - $signed(TC3) + $signed(TC4)
                                          - $signed(TC5) + $signed(TC6);
        localparam logic [15:0] SQ    = hlva_pkg::q30_to_q15(SS);
        localparam logic [15:0] CQ    = hlva_pkg::q30_to_q15(SC);
        localparam logic [15:0] SIN_V = SWAP ? CQ : SQ;
        localparam logic [15:0] COS_M = SWAP ? SQ : CQ;
        localparam logic [15:0] COS_V = NEG ? (16'd0 - COS_M) : COS_M;
        assign trig_tab[k] = {COS_V, SIN_V};
    end

    // ---- configuration ----
    logic [DW-1:0] width_reg;
    logic [DW-1:0] height_reg;
    logic          cfg_wr;

    assign cfg_wr = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= hlva_pkg::IMAGE_WIDTH_RST;
            height_reg <= hlva_pkg::IMAGE_HEIGHT_RST;
        end else if (cfg_wr) begin
            if (paddr[2] == hlva_pkg::REG_IMAGE_WIDTH) begin
                width_reg <= pwdata[DW-1:0];
            end else begin
                height_reg <= pwdata[DW-1:0];
            end
        end
    end

    assign prdata = (paddr[2] == hlva_pkg::REG_IMAGE_HEIGHT) ? {21'd0, height_reg}
                                                             : {21'd0, width_reg};
    assign pready = 1'b1;

    logic [DW-1:0] wd_eff;
    logic [DW-1:0] ht_eff;

    assign wd_eff = (width_reg  > DIM_MAX) ? DIM_MAX : width_reg;
    assign ht_eff = (height_reg > DIM_MAX) ? DIM_MAX : height_reg;

    // ---- dividers ----
    logic          div_start;
    logic          x_done;
    logic          y_done;
    logic [QW-1:0] x_q;
    logic [QW-1:0] y_q;

    hlva_divider u_div_x (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (s_data.pixel_x),
        .denom    (wd_eff),
        .done     (x_done),
        .quotient (x_q)
    );

    hlva_divider u_div_y (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .numer    (s_data.pixel_y),
        .denom    (ht_eff),
        .done     (y_done),
        .quotient (y_q)
    );

    // ---- vote store ----
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [31:0]   ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [31:0]   ram_rdata;

    hlva_ram #(
        .WIDTH (32),
        .DEPTH (NCELLS)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---- control registers ----
    logic [2:0]          state_reg, state_next;
    logic [AW-1:0]       clr_reg, clr_next;
    logic                clr_reply_reg, clr_reply_next;
    logic [KW-1:0]       k_reg, k_next;
    logic [CW-1:0]       votes_reg, votes_next;
    logic [15:0]         w_reg, w_next;
    logic [31:0]         res_cell_reg, res_cell_next;
    logic [8:0]          res_votes_reg, res_votes_next;
    logic                m_valid_reg, m_valid_next;
    hlva_pkg::result_t   m_data_reg, m_data_next;

    // ---- angle pipe ----
    logic                s1_vld_reg;
    logic [KW-1:0]       s1_k_reg;
    logic [31:0]         s1_trig_reg;
    logic                s2_vld_reg;
    logic [KW-1:0]       s2_k_reg;
    logic signed [32:0]  s2_xc_reg;
    logic [31:0]         s2_ys_reg;
    logic                s3_vld_reg;
    logic [KW-1:0]       s3_k_reg;
    logic                s3_pos_reg;
    logic [31:0]         s3_r_reg;
    logic                s4_vld_reg;
    logic [KW-1:0]       s4_k_reg;
    logic                s4_pos_reg;
    logic [61:0]         s4_prod_reg;
    logic                s5_vld_reg;
    logic [AW-1:0]       s5_addr_reg;

    logic signed [33:0]  r_sum;
    logic [10:0]         s4_rb;
    logic                s4_hit;
    logic [AW-1:0]       s4_addr;
    logic [32:0]         wsum;
    logic [31:0]         wsat;
    logic                pipe_busy;

    assign r_sum   = {s2_xc_reg[32], s2_xc_reg} + $signed({2'b00, s2_ys_reg});
    assign s4_rb   = s4_prod_reg[61:51];
    assign s4_hit  = s4_vld_reg && s4_pos_reg && (s4_rb != 11'd0) && (s4_rb < R_LIM);
    assign s4_addr = AW'(s4_k_reg) * AW'(RADIUS_BINS) + AW'(s4_rb);
    assign wsum    = {1'b0, ram_rdata} + {17'd0, w_reg};
    assign wsat    = wsum[32] ? 32'hFFFF_FFFF : wsum[31:0];
    assign pipe_busy = s1_vld_reg || s2_vld_reg || s3_vld_reg || s4_vld_reg || s5_vld_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
        end else begin
            s1_vld_reg <= (state_reg == ST_WALK);
            s2_vld_reg <= s1_vld_reg;
            s3_vld_reg <= s2_vld_reg;
            s4_vld_reg <= s3_vld_reg;
            s5_vld_reg <= s4_hit;
        end
    end

    always_ff @(posedge aclk) begin
        s1_k_reg    <= k_reg;
        s1_trig_reg <= trig_tab[k_reg];
        s2_k_reg    <= s1_k_reg;
        s2_xc_reg   <= $signed({1'b0, x_q}) * $signed(s1_trig_reg[31:16]);
        s2_ys_reg   <= y_q * s1_trig_reg[15:0];
        s3_k_reg    <= s2_k_reg;
        s3_pos_reg  <= (r_sum > 0);
        s3_r_reg    <= r_sum[31:0];
        s4_k_reg    <= s3_k_reg;
        s4_pos_reg  <= s3_pos_reg;
        s4_prod_reg <= s3_r_reg * R_SCALE;
        s5_addr_reg <= s4_addr;
    end

    // ---- sequencer ----
    logic          accept;
    logic          read_ok;
    logic [AW-1:0] read_addr;
    logic          vote_skip;

    assign s_ready   = (state_reg == ST_IDLE);
    assign accept    = s_valid && s_ready;
    assign read_ok   = ({3'd0, s_data.angle_bin} < A_LIM) && ({3'd0, s_data.radius_bin} < R_LIM);
    assign read_addr = AW'(s_data.angle_bin) * AW'(RADIUS_BINS) + AW'(s_data.radius_bin);
    assign vote_skip = (s_data.edge_weight == 16'd0) || ({1'b0, s_data.pixel_x} >= wd_eff)
                    || ({1'b0, s_data.pixel_y} >= ht_eff);

    always_comb begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        clr_reply_next = clr_reply_reg;
        k_next         = k_reg;
        votes_next     = votes_reg;
        w_next         = w_reg;
        res_cell_next  = res_cell_reg;
        res_votes_next = res_votes_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        div_start      = 1'b0;

        if (s5_vld_reg) begin
            votes_next = votes_reg + 1'b1;
        end

        case (state_reg)
            ST_CLEAR: begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == CLR_LAST) begin
                    res_cell_next  = 32'd0;
                    res_votes_next = 9'd0;
                    state_next     = clr_reply_reg ? ST_OUT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    res_cell_next  = 32'd0;
                    res_votes_next = 9'd0;
                    w_next         = s_data.edge_weight;
                    votes_next     = '0;
                    case (s_data.operation)
                        hlva_pkg::OP_VOTE: begin
                            if (vote_skip) begin
                                state_next = ST_OUT;
                            end else begin
                                div_start  = 1'b1;
                                state_next = ST_DIV;
                            end
                        end
                        hlva_pkg::OP_READ: begin
                            state_next = read_ok ? ST_RDWAIT : ST_OUT;
                        end
                        hlva_pkg::OP_CLEAR: begin
                            clr_next       = '0;
                            clr_reply_next = 1'b1;
                            state_next     = ST_CLEAR;
                        end
                        default: begin
                            state_next = ST_OUT;
                        end
                    endcase
                end
            end
            ST_DIV: begin
                if (x_done && y_done) begin
                    k_next     = '0;
                    state_next = ST_WALK;
                end
            end
            ST_WALK: begin
                k_next = k_reg + 1'b1;
                if (k_reg == K_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!pipe_busy) begin
                    res_votes_next = 9'(votes_reg);
                    state_next     = ST_OUT;
                end
            end
            ST_RDWAIT: begin
                res_cell_next = ram_rdata;
                state_next    = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next           = 1'b1;
                    m_data_next.cell_value = res_cell_reg;
                    m_data_next.votes_cast = res_votes_reg;
                    state_next             = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            clr_reply_reg <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            clr_reply_reg <= clr_reply_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        k_reg         <= k_next;
        votes_reg     <= votes_next;
        w_reg         <= w_next;
        res_cell_reg  <= res_cell_next;
        res_votes_reg <= res_votes_next;
        m_data_reg    <= m_data_next;
    end

    // store ports: clearing and the pipe never overlap with a read beat
    assign ram_we    = (state_reg == ST_CLEAR) || s5_vld_reg;
    assign ram_waddr = (state_reg == ST_CLEAR) ? clr_reg : s5_addr_reg;
    assign ram_wdata = (state_reg == ST_CLEAR) ? 32'd0 : wsat;
    assign ram_re    = s4_hit || (accept && s_data.operation == hlva_pkg::OP_READ && read_ok);
    assign ram_raddr = s4_hit ? s4_addr : read_addr;

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

[src/hlva_ram.sv]
// ----------------------------------------------------------------------------
// hlva_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module hlva_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/hlva_divider.sv]
// ----------------------------------------------------------------------------
// hlva_divider
// Radix-2 restoring divider: quotient = floor(numer * 2^16 / denom),
// one quotient bit per cycle. Requires numer < denom.
// ----------------------------------------------------------------------------
module hlva_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [9:0]                     numer,
    input  logic [hlva_pkg::DIM_W-1:0]     denom,
    output logic                           done,
    output logic [hlva_pkg::QUOT_W-1:0]    quotient
);

    localparam int CNT_W = $clog2(hlva_pkg::QUOT_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(hlva_pkg::QUOT_W - 1);

    logic                          busy_reg;
    logic [CNT_W-1:0]              cnt_reg;
    logic [hlva_pkg::DIM_W-1:0]    rem_reg;
    logic [hlva_pkg::DIM_W-1:0]    den_reg;
    logic [hlva_pkg::QUOT_W-1:0]   quo_reg;

    logic [hlva_pkg::DIM_W:0]      trial;
    logic [hlva_pkg::DIM_W:0]      diff;
    logic                          ge;

    assign trial = {rem_reg, 1'b0};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = (trial >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
        end else if (start) begin
            busy_reg <= 1'b1;
        end else if (busy_reg && cnt_reg == CNT_LAST) begin
            busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= hlva_pkg::DIM_W'(numer);
            den_reg <= denom;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[hlva_pkg::DIM_W-1:0] : trial[hlva_pkg::DIM_W-1:0];
            quo_reg <= {quo_reg[hlva_pkg::QUOT_W-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done     = !busy_reg;
    assign quotient = quo_reg;

endmodule

[src/hlva_checker.sv]
// ----------------------------------------------------------------------------
// hlva_checker
// Port-level assertions for the Hough line vote accumulator, bound to the top.
// ----------------------------------------------------------------------------
module hlva_checker #(
    parameter int ANGLE_BINS = hlva_pkg::ANGLE_BINS_DEF
) (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input hlva_pkg::result_t               m_data,
    input logic                            psel,
    input logic                            penable,
    input logic                            pwrite,
    input logic [hlva_pkg::CFG_ADDR_W-1:0] paddr,
    input logic [31:0]                     pwdata,
    input logic [31:0]                     prdata
);

    // stalled result beat holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed while stalled");

    // store is swept after reset before any beat is taken
    a_clear_after_reset: assert property (@(posedge aclk)
        !aresetn |=> !s_ready)
        else $error("input ready straight after reset");

    a_vote_no_cell: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.votes_cast != 9'd0) |-> (m_data.cell_value == 32'd0))
        else $error("vote result carries a cell value");

    a_votes_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({23'd0, m_data.votes_cast} <= 32'(ANGLE_BINS)))
        else $error("more votes than angle bins");

    a_cfg_readback: assert property (@(posedge aclk) disable iff (!aresetn)
        (psel && penable && pwrite) ##1 (psel && !pwrite && (paddr == $past(paddr)))
        |-> (prdata == {21'd0, $past(pwdata[10:0])}))
        else $error("register read-back differs from last write");

endmodule

bind hough_line_vote_accumulator hlva_checker #(
    .ANGLE_BINS (ANGLE_BINS)
) u_hlva_checker (.*);

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the Hough line vote accumulator. A queue of beats
// (a directed opening, then random phases under several image sizes set over
// APB) feeds a bursty driver; a monitor checks every result beat against a
// bit-exact predictor of the vote store while the receiver stalls at random.
// ----------------------------------------------------------------------------
module testbench;
    import hlva_pkg::*;

    localparam int NA               = ANGLE_BINS_DEF;
    localparam int NR               = RADIUS_BINS_DEF;
    localparam int DIM_CAP          = MAX_DIM_DEF;
    localparam int CELLS            = NA * NR;
    localparam int PHASES           = 9;
    localparam int BEATS_PER_PHASE  = 67;
    localparam int STALL_LIMIT      = 300000;
    localparam int SETTLE_CYCLES    = 30;
    localparam int TAIL_CYCLES      = 300;
    localparam int MAX_PRINTS       = 40;

    typedef enum int {RX_OPEN, RX_COIN, RX_PULSE, RX_SPARSE} rx_mode_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    vote_in_t              s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    result_t               m_data;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr   = '0;
    logic [31:0]           pwdata  = '0;
    logic [31:0]           prdata;
    logic                  pready;

    hough_line_vote_accumulator dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #6 aclk = ~aclk;

    logic [31:0]      tally [CELLS];
    int               cos_q15 [NA];
    int               sin_q15 [NA];
    logic [DIM_W-1:0] cfg_width  = IMAGE_WIDTH_RST;
    logic [DIM_W-1:0] cfg_height = IMAGE_HEIGHT_RST;

    vote_in_t    pending_beats [$];
    result_t     awaited_results [$];
    logic [15:0] hot_cells [$];

    int beats_queued    = 0;
    int results_checked = 0;
    int err_count       = 0;
    int clears_left     = 2;

    int n_votes = 0, n_votes_hit = 0, n_cells_voted = 0;
    int n_reads = 0, n_reads_nz = 0, n_clears = 0, n_nops = 0;

    task automatic flag_mismatch(input string what);
        if (err_count < MAX_PRINTS) begin
            $display("MISMATCH @%0t: %s", $realtime, what);
        end
        err_count++;
    endtask

    // ------------------------------------------------------------------
    // fixed-point trig, Q30 angle in [0, pi/4], Q1.15 magnitudes out
    // ------------------------------------------------------------------
    function automatic int to_q15(input longint v);
        logic [63:0] q;
        if (v < 0) begin
            v = 0;
        end
        q = (64'(v) + 64'd16384) >> 15;
        return (q > 64'd32767) ? 32767 : int'(q);
    endfunction

    function automatic void trig_series(input logic [63:0] a, output int sn, output int cs);
        logic [63:0] x2, ts, tc, n;
        longint      ss, sc;
        x2 = (a * a) >> 30;
        ts = a;
        tc = ONE_Q30;
        ss = longint'(a);
        sc = longint'(ONE_Q30);
        for (n = 1; n <= 6; n++) begin
            ts = ((ts * x2) >> 30) / ((2 * n) * (2 * n + 1));
            tc = ((tc * x2) >> 30) / ((2 * n - 1) * (2 * n));
            if (n[0]) begin
                ss -= longint'(ts);
                sc -= longint'(tc);
            end else begin
                ss += longint'(ts);
                sc += longint'(tc);
            end
        end
        sn = to_q15(ss);
        cs = to_q15(sc);
    endfunction

    initial begin
        logic [63:0] kk;
        logic        neg;
        int          sn, cs, k, c;
        for (k = 0; k < NA; k++) begin
            kk  = k;
            neg = 1'b0;
            if (2 * kk > NA) begin
                kk  = NA - kk;
                neg = 1'b1;
            end
            if (4 * kk > NA) begin
                trig_series(((NA - 2 * kk) * PI_Q30) / (2 * NA), cs, sn);
            end else begin
                trig_series((kk * PI_Q30) / NA, sn, cs);
            end
            sin_q15[k] = sn;
            cos_q15[k] = neg ? -cs : cs;
        end
        for (c = 0; c < CELLS; c++) begin
            tally[c] = '0;
        end
    end

    function automatic int eff_dim(input logic [DIM_W-1:0] r);
        return (r > DIM_CAP) ? DIM_CAP : int'(r);
    endfunction

    function automatic bit in_image(input logic [9:0] px, input logic [9:0] py);
        return (px < eff_dim(cfg_width)) && (py < eff_dim(cfg_height));
    endfunction

    // radius bin hit by a pixel at angle k; 0 when nothing is voted
    function automatic int radius_bin_of(input logic [9:0] px, input logic [9:0] py,
                                         input int k);
        longint      x, y, r;
        logic [63:0] ru, prod;
        x = longint'((64'(px) << 16) / 64'(eff_dim(cfg_width)));
        y = longint'((64'(py) << 16) / 64'(eff_dim(cfg_height)));
        r = x * cos_q15[k] + y * sin_q15[k];
        if (r <= 0) begin
            return 0;
        end
        ru   = r;
        prod = (ru * 64'(NR) * 64'(INV_SQRT2_Q20)) >> 51;
        if (prod >= 64'(NR)) begin
            return 0;
        end
        return int'(prod);
    endfunction

    // applies one beat to the store copy and returns its result
    function automatic result_t hough_outcome(input vote_in_t b);
        result_t     res;
        int          k, rb, idx, c;
        logic [32:0] sum;
        res = '0;
        case (b.operation)
            OP_VOTE: begin
                n_votes++;
                if (b.edge_weight != 0 && in_image(b.pixel_x, b.pixel_y)) begin
                    for (k = 0; k < NA; k++) begin
                        rb = radius_bin_of(b.pixel_x, b.pixel_y, k);
                        if (rb != 0) begin
                            idx        = k * NR + rb;
                            sum        = {1'b0, tally[idx]} + 33'(b.edge_weight);
                            tally[idx] = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                            res.votes_cast++;
                        end
                    end
                end
                if (res.votes_cast != 0) begin
                    n_votes_hit++;
                end
                n_cells_voted += res.votes_cast;
            end
            OP_READ: begin
                n_reads++;
                if (b.angle_bin < NA && b.radius_bin < NR) begin
                    res.cell_value = tally[int'(b.angle_bin) * NR + int'(b.radius_bin)];
                end
                if (res.cell_value != 0) begin
                    n_reads_nz++;
                end
            end
            OP_CLEAR: begin
                n_clears++;
                for (c = 0; c < CELLS; c++) begin
                    tally[c] = '0;
                end
            end
            default: begin
                n_nops++;
            end
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // stimulus construction
    // ------------------------------------------------------------------
    function automatic vote_in_t mk_beat(input logic [1:0] op, input int px, input int py,
                                         input int w, input int ab, input int rb);
        vote_in_t b;
        b.operation   = op;
        b.pixel_x     = 10'(px);
        b.pixel_y     = 10'(py);
        b.edge_weight = 16'(w);
        b.angle_bin   = 8'(ab);
        b.radius_bin  = 8'(rb);
        return b;
    endfunction

    task automatic queue_beat(input vote_in_t b);
        pending_beats.push_back(b);
        beats_queued++;
    endtask

    function automatic vote_in_t random_beat();
        vote_in_t b;
        int       sel, wd, ht, k, rb;
        logic [15:0] hot_pick;
        b.operation   = OP_NOP;
        b.pixel_x     = 10'($urandom);
        b.pixel_y     = 10'($urandom);
        b.edge_weight = 16'($urandom);
        b.angle_bin   = 8'($urandom);
        b.radius_bin  = 8'($urandom);
        wd  = eff_dim(cfg_width);
        ht  = eff_dim(cfg_height);
        sel = $urandom_range(0, 99);
        if (sel < 55) begin
            b.operation = OP_VOTE;
            case ($urandom_range(0, 9))
                0:       b.edge_weight = 16'd0;
                1:       b.edge_weight = 16'hFFFF;
                default: ;
            endcase
            if (wd > 0 && $urandom_range(0, 99) < 85) begin
                b.pixel_x = 10'($urandom_range(0, wd - 1));
            end
            if (ht > 0 && $urandom_range(0, 99) < 85) begin
                b.pixel_y = 10'($urandom_range(0, ht - 1));
            end
            if (b.edge_weight != 0 && in_image(b.pixel_x, b.pixel_y)) begin
                k  = $urandom_range(0, NA - 1);
                rb = radius_bin_of(b.pixel_x, b.pixel_y, k);
                if (rb != 0) begin
                    hot_cells.push_back({8'(k), 8'(rb)});
                    if (hot_cells.size() > 64) begin
                        void'(hot_cells.pop_front());
                    end
                end
            end
        end else if (sel < 92) begin
            b.operation = OP_READ;
            if (hot_cells.size() > 0 && $urandom_range(0, 99) < 60) begin
                hot_pick     = hot_cells[$urandom_range(0, hot_cells.size() - 1)];
                b.angle_bin  = hot_pick[15:8];
                b.radius_bin = hot_pick[7:0];
            end
        end else if (sel >= 97 && clears_left > 0) begin
            b.operation = OP_CLEAR;
            clears_left--;
        end
        return b;
    endfunction

    // ------------------------------------------------------------------
    // APB: write a register, then read it back
    // ------------------------------------------------------------------
    task automatic cfg_write(input logic idx, input logic [DIM_W-1:0] val);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {21'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        pwrite  <= 1'b0;
        penable <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) begin
            cfg_width = val;
        end else begin
            cfg_height = val;
        end
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        if (prdata !== {21'd0, val}) begin
            flag_mismatch($sformatf("register %0d read back %0h, wrote %0h",
                                    idx, prdata, val));
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic wait_drained();
        while (results_checked != beats_queued) begin
            @(posedge aclk);
        end
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // ------------------------------------------------------------------
    // driver: bursts of beats with random gaps
    // ------------------------------------------------------------------
    int burst_left = 0;
    int gap_left   = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                awaited_results.push_back(hough_outcome(s_data));
            end
            if (!(s_valid && !s_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    s_data  <= pending_beats.pop_front();
                    s_valid <= 1'b1;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                                 : $urandom_range(1, 8);
                        gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // receiver back-pressure in four modes, each chosen at random
    // ------------------------------------------------------------------
    rx_mode_t rx_mode = RX_OPEN;
    int       rx_left = 0;
    int       rx_tick = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            rx_tick++;
            if (rx_left == 0) begin
                rx_mode = rx_mode_t'($urandom_range(0, 3));
                rx_left = $urandom_range(50, 2000);
            end else begin
                rx_left--;
            end
            case (rx_mode)
                RX_OPEN:  m_ready <= 1'b1;
                RX_COIN:  m_ready <= 1'($urandom_range(0, 1));
                RX_PULSE: m_ready <= ((rx_tick % 40) >= 30);
                default:  m_ready <= ($urandom_range(0, 15) != 0);
            endcase
        end
    end

    // ------------------------------------------------------------------
    // monitor
    // ------------------------------------------------------------------
    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (awaited_results.size() == 0) begin
                flag_mismatch($sformatf("unexpected result beat: cell %0h votes %0d",
                                        m_data.cell_value, m_data.votes_cast));
            end else begin
                want = awaited_results.pop_front();
                if (m_data.cell_value !== want.cell_value) begin
                    flag_mismatch($sformatf("beat %0d cell_value %0h, want %0h",
                                            results_checked, m_data.cell_value,
                                            want.cell_value));
                end
                if (m_data.votes_cast !== want.votes_cast) begin
                    flag_mismatch($sformatf("beat %0d votes_cast %0d, want %0d",
                                            results_checked, m_data.votes_cast,
                                            want.votes_cast));
                end
                results_checked++;
            end
        end
    end

    // watchdog on handshake activity; allows for the post-reset and clear sweeps
    int stall_cycles = 0;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles++;
        end
        if (stall_cycles >= STALL_LIMIT) begin
            $display("watchdog: no beat moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // sequence
    // ------------------------------------------------------------------
    initial begin
        int p, i, w, h, rb0, rb64, rb128, rb_late;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // directed opening at the reset image size
        queue_beat(mk_beat(OP_NOP, 1023, 1023, 65535, 255, 255));
        queue_beat(mk_beat(OP_READ, 0, 0, 0, 0, 0));
        queue_beat(mk_beat(OP_READ, 1023, 1023, 65535, 255, 255));
        queue_beat(mk_beat(OP_VOTE, 100, 100, 0, 0, 0));
        queue_beat(mk_beat(OP_VOTE, 0, 0, 65535, 0, 0));
        queue_beat(mk_beat(OP_VOTE, 511, 511, 65535, 255, 255));
        queue_beat(mk_beat(OP_VOTE, 511, 0, 1, 0, 0));
        queue_beat(mk_beat(OP_VOTE, 0, 511, 16'h1000, 0, 0));
        queue_beat(mk_beat(OP_VOTE, 512, 10, 65535, 0, 0));
        queue_beat(mk_beat(OP_VOTE, 10, 1023, 65535, 0, 0));
        queue_beat(mk_beat(OP_VOTE, 1023, 1023, 65535, 0, 0));
        queue_beat(mk_beat(OP_VOTE, 256, 256, 65535, 0, 0));
        queue_beat(mk_beat(OP_VOTE, 256, 256, 65535, 0, 0));
        rb0   = radius_bin_of(10'd256, 10'd256, 0);
        rb64  = radius_bin_of(10'd256, 10'd256, 64);
        rb128 = radius_bin_of(10'd256, 10'd256, 128);
        queue_beat(mk_beat(OP_READ, 0, 0, 0, 0, rb0));
        queue_beat(mk_beat(OP_READ, 0, 0, 0, 64, rb64));
        queue_beat(mk_beat(OP_READ, 0, 0, 0, 128, rb128));
        queue_beat(mk_beat(OP_READ, 0, 0, 0, 0, 0));
        queue_beat(mk_beat(OP_CLEAR, 1023, 1023, 65535, 255, 255));
        queue_beat(mk_beat(OP_READ, 0, 0, 0, 0, rb0));
        queue_beat(mk_beat(OP_VOTE, 300, 200, 7, 0, 0));
        rb_late = radius_bin_of(10'd300, 10'd200, 5);
        queue_beat(mk_beat(OP_READ, 0, 0, 0, 5, rb_late));
        wait_drained();

        // random phases, each under its own image size; drained in between
        for (p = 0; p < PHASES; p++) begin
            case (p)
                0:       begin w = 1024; h = 1024; end
                1:       begin w = 2047; h = 2047; end
                2:       begin w = 1;    h = 1;    end
                3:       begin w = 0;    h = 300;  end
                4:       begin w = 300;  h = 0;    end
                5:       begin w = 640;  h = 480;  end
                6:       begin w = 37;   h = 1000; end
                7:       begin w = 1000; h = 37;   end
                default: begin w = $urandom_range(1, 1024); h = $urandom_range(1, 1024); end
            endcase
            cfg_write(REG_IMAGE_WIDTH, DIM_W'(w));
            cfg_write(REG_IMAGE_HEIGHT, DIM_W'(h));
            for (i = 0; i < BEATS_PER_PHASE; i++) begin
                queue_beat(random_beat());
            end
            wait_drained();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (awaited_results.size() != 0) begin
            flag_mismatch($sformatf("%0d results never arrived", awaited_results.size()));
        end

        $display("covered %0d votes (%0d landed, %0d cells hit), %0d reads (%0d non-zero)",
                 n_votes, n_votes_hit, n_cells_voted, n_reads, n_reads_nz);
        $display("plus %0d clears and %0d idle ops over %0d image sizes; %0d mismatches",
                 n_clears, n_nops, PHASES + 1, err_count);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
